FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue: request and
// response payloads, the stored entry, status codes and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	// queue depth, one cell per entry
	localparam int CAPACITY = 16;
	// entry count must hold CAPACITY itself
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// fixed width of the occupancy field in the response
	localparam int OCC_W    = 5;
	localparam int DATA_W   = 32;

	// request kinds
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	// response status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                     req_type;
		logic signed [DATA_W-1:0] item_value;
		logic signed [DATA_W-1:0] item_priority;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] out_value;
		logic signed [DATA_W-1:0] out_priority;
		logic [OCC_W-1:0]         occupancy;
		logic                     now_empty;
	} rsp_t;

	// one stored pair
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t item;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. On a push it keeps its entry, takes the new
// item or takes its upper neighbor's entry; on a pop it takes its lower
// neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
	input  wire                 clk,
	input  spq_pkg::cell_ctl_t  ctl,
	input  wire                 is_head,
	input  wire                 occupied,
	input  wire                 prev_take,
	input  spq_pkg::entry_t     prev_entry,
	input  spq_pkg::entry_t     next_entry,
	output logic                take,
	output spq_pkg::entry_t     entry
);
	import spq_pkg::*;

	entry_t entry_q;
	logic   gt;
	logic   ge;

	// insertion point compare: strict at the head, ties go ahead of equals below
	assign gt   = $signed(ctl.item.prio) >  $signed(entry_q.prio);
	assign ge   = $signed(ctl.item.prio) >= $signed(entry_q.prio);
	assign take = ctl.push & (!occupied | (is_head ? gt : ge));

	// slot update
	always_ff @(posedge clk) begin
		if (ctl.push && take) begin
			entry_q <= prev_take ? prev_entry : ctl.item;
		end else if (ctl.pop) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue held as a chain of sorted register cells, highest
// priority at the head. Enqueue inserts by shifting the tail down; dequeue
// pops the head by shifting the chain up.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------
//   request | req_valid | req_stall | req (spq_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp (spq_pkg::rsp_t)
//
// All cells compare against the broadcast priority and shift in the same
// edge, so one request per clock is sustained while req_stall is low.
// The result shows in the output register in the cycle after the transfer.
// Reset clears the entry count and the output valid; cell contents are left.
// req_stall is high while a result waits in the output register under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_top (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  spq_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output spq_pkg::rsp_t  rsp
);
	import spq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             accept;
	logic             is_full;
	logic             no_entries;
	cell_ctl_t        ctl;
	rsp_t             rsp_nxt;

	entry_t           cell_entry [CAPACITY];
	logic             cell_take  [CAPACITY];

	// handshake
	assign req_stall  = rsp_valid_q & rsp_stall;
	assign accept     = req_valid & ~req_stall;
	assign is_full    = (count_q == CNT_W'(CAPACITY));
	assign no_entries = (count_q == '0);

	// control broadcast to the chain
	always_comb begin
		ctl.push = accept & (req.req_type == REQ_ENQ) & ~is_full;
		ctl.pop  = accept & (req.req_type == REQ_DEQ) & ~no_entries;
		ctl.item.value = req.item_value;
		ctl.item.prio  = req.item_priority;
	end

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_t;
		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_t = 1'b0;
		end else begin : g_body
			assign prev_e = cell_entry[i-1];
			assign prev_t = cell_take[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_mid
			assign next_e = cell_entry[i+1];
		end
		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.is_head    (i == 0),
			.occupied   (CNT_W'(i) < count_q),
			.prev_take  (prev_t),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.take       (cell_take[i]),
			.entry      (cell_entry[i])
		);
	end

	// next count and result word
	always_comb begin
		count_nxt = count_q;
		if (ctl.push) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
		rsp_nxt.status       = ST_DONE;
		rsp_nxt.out_value    = '0;
		rsp_nxt.out_priority = '0;
		if (req.req_type == REQ_DEQ) begin
			if (no_entries) begin
				rsp_nxt.status = ST_EMPTY;
			end else begin
				rsp_nxt.out_value    = cell_entry[0].value;
				rsp_nxt.out_priority = cell_entry[0].prio;
			end
		end else if (is_full) begin
			rsp_nxt.status = ST_FULL;
		end
		rsp_nxt.occupancy = OCC_W'(count_nxt);
		rsp_nxt.now_empty = (count_nxt == '0);
	end

	// count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("dequeue did not shrink the queue");

	a_rsp_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("no result after request transfer");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> $signed(cell_entry[0].prio) >= $signed(cell_entry[1].prio))
		else $error("head out of priority order");

	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.occupancy == OCC_W'(CAPACITY))
		else $error("full status with queue not full");
`endif

endmodule

`default_nettype wire

FILE: sim/sorted_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Self-checking bench for the sorted priority queue. Requests go in through
// the valid/stall request channel in bursts with random gaps. Each transfer is
// run through a shadow queue kept in this bench, and every result transfer is
// compared field by field with the oldest outstanding prediction. Directed
// cases cover empty dequeue, extreme and equal priorities, fill to capacity
// and the dropped enqueue. Random traffic then swings the fill level between
// empty and full.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int RANDOM_ITEMS = 1800;
	localparam int STREAM_ITEMS = 200;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_style_e;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	req_t  req       = '0;
	logic  req_stall;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	// shadow copy of the queue contents
	logic signed [DATA_W-1:0] shadow_value [CAPACITY];
	logic signed [DATA_W-1:0] shadow_prio  [CAPACITY];
	int                       shadow_count = 0;

	// results owed by the block, oldest first
	rsp_t owed_rsp [$];

	int   n_errors   = 0;
	int   n_checked  = 0;
	int   n_enq      = 0;
	int   n_deq      = 0;
	int   n_dropped  = 0;
	int   n_on_empty = 0;
	int   peak_fill  = 0;
	int   idle_count = 0;
	int   burst_left = 0;
	bit   stream_mode = 1'b0;

	stall_style_e stall_style = STALL_NONE;
	int           stall_phase = 0;
	int           stall_run   = 0;
	logic         stall_hold  = 1'b0;

	sorted_priority_queue_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// apply one request to the shadow queue and return the result it owes
	function automatic rsp_t serve_request(req_t r);
		rsp_t res;
		int   slot;
		int   i;
		res = '0;
		res.status = ST_DONE;
		if (r.req_type == REQ_ENQ) begin
			if (shadow_count >= CAPACITY) begin
				res.status = ST_FULL;
				n_dropped++;
			end else begin
				// new head only on strictly higher priority, else after all strictly higher
				if (shadow_count == 0 || r.item_priority > shadow_prio[0]) begin
					slot = 0;
				end else begin
					slot = 1;
					while (slot < shadow_count && r.item_priority < shadow_prio[slot])
						slot++;
				end
				for (i = shadow_count; i > slot; i--) begin
					shadow_value[i] = shadow_value[i-1];
					shadow_prio[i]  = shadow_prio[i-1];
				end
				shadow_value[slot] = r.item_value;
				shadow_prio[slot]  = r.item_priority;
				shadow_count++;
				n_enq++;
			end
		end else begin
			if (shadow_count == 0) begin
				res.status = ST_EMPTY;
				n_on_empty++;
			end else begin
				res.out_value    = shadow_value[0];
				res.out_priority = shadow_prio[0];
				for (i = 1; i < shadow_count; i++) begin
					shadow_value[i-1] = shadow_value[i];
					shadow_prio[i-1]  = shadow_prio[i];
				end
				shadow_count--;
				n_deq++;
			end
		end
		res.occupancy = OCC_W'(shadow_count);
		res.now_empty = (shadow_count == 0);
		if (shadow_count > peak_fill)
			peak_fill = shadow_count;
		return res;
	endfunction

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		n_errors++;
	endtask

	// compare one result transfer with the oldest outstanding prediction
	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		if (owed_rsp.size() == 0) begin
			report("result transfer with nothing outstanding");
			return;
		end
		want = owed_rsp.pop_front();
		n_checked++;
		if (got.status !== want.status)
			report($sformatf("status got %0d want %0d", got.status, want.status));
		if (got.out_value !== want.out_value)
			report($sformatf("out_value got %0d want %0d", got.out_value, want.out_value));
		if (got.out_priority !== want.out_priority)
			report($sformatf("out_priority got %0d want %0d",
				got.out_priority, want.out_priority));
		if (got.occupancy !== want.occupancy)
			report($sformatf("occupancy got %0d want %0d", got.occupancy, want.occupancy));
		if (got.now_empty !== want.now_empty)
			report($sformatf("now_empty got %0b want %0b", got.now_empty, want.now_empty));
	endtask

	// result check first, then prediction for the request taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				check_rsp(rsp);
			if (req_valid && !req_stall)
				owed_rsp.push_back(serve_request(req));
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count >= IDLE_LIMIT) begin
				$display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// receiver stall pattern, the style is redrawn whenever its phase runs out
	always @(posedge clk) begin
		if (!arst_n || stream_mode) begin
			rsp_stall <= 1'b0;
		end else begin
			if (stall_phase == 0) begin
				stall_style = stall_style_e'($urandom_range(0, 3));
				stall_phase = $urandom_range(16, 160);
			end
			stall_phase--;
			case (stall_style)
				STALL_NONE:  rsp_stall <= 1'b0;
				STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
				STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: begin
					if (stall_run == 0) begin
						stall_run  = $urandom_range(1, 24);
						stall_hold = ~stall_hold;
					end
					stall_run--;
					rsp_stall <= stall_hold;
				end
			endcase
		end
	end

	// drive one request and hold it until the transfer
	task automatic send_req(input logic kind, input logic signed [DATA_W-1:0] val,
			input logic signed [DATA_W-1:0] prio);
		req_valid <= 1'b1;
		req       <= '{req_type: kind, item_value: val, item_priority: prio};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// sender bursts with random gaps between them
	task automatic issue(input logic kind, input logic signed [DATA_W-1:0] val,
			input logic signed [DATA_W-1:0] prio);
		int gap;
		if (!stream_mode) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
		end
		send_req(kind, val, prio);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return 32'sh0;
			default: return 32'shffffffff;
		endcase
	endfunction

	// priorities lean on a small pool so that ties are common
	function automatic logic signed [DATA_W-1:0] rand_prio();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return $signed(32'($urandom_range(0, 7))) - 32'sd4;
		else if (pick == 4)
			return pick_extreme();
		else
			return $urandom;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_value();
		return ($urandom_range(0, 7) == 0) ? pick_extreme() : $signed($urandom);
	endfunction

	// dequeue with nothing held
	task automatic test_empty_dequeue();
		issue(REQ_DEQ, 32'sh7fffffff, 32'sh80000000);
	endtask

	// fill to capacity with extreme and tied priorities, then one dropped enqueue
	task automatic test_fill_overflow();
		logic signed [DATA_W-1:0] prios [CAPACITY] = '{
			32'sh0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd5, 32'sd5, 32'sd5,
			32'sh7fffffff, 32'sh80000000, 32'sd1, -32'sd5, 32'sd100, 32'sh0,
			-32'sd1, 32'sd3, 32'sd2};
		logic signed [DATA_W-1:0] vals [CAPACITY] = '{
			32'sh80000000, 32'sh7fffffff, 32'sh0, -32'sd1, 32'sd11, 32'sd12, 32'sd13,
			32'sd21, 32'sd22, 32'sh55555555, 32'shaaaaaaaa, 32'sd7, 32'sd8,
			32'sd9, 32'sd10, 32'sd14};
		int i;
		for (i = 0; i < CAPACITY; i++)
			issue(REQ_ENQ, vals[i], prios[i]);
		issue(REQ_ENQ, 32'sd99, 32'sh7fffffff);
	endtask

	// pop a few heads in order
	task automatic test_drain_head();
		int i;
		for (i = 0; i < 4; i++)
			issue(REQ_DEQ, rand_value(), rand_prio());
	endtask

	// random mix, enqueue share changes every segment so the fill swings end to end
	task automatic test_random_traffic(input int count);
		int   n;
		int   enq_pct;
		logic kind;
		enq_pct = 50;
		for (n = 0; n < count; n++) begin
			if (n % 64 == 0) begin
				case ($urandom_range(0, 2))
					0:       enq_pct = 15;
					1:       enq_pct = 50;
					default: enq_pct = 85;
				endcase
			end
			kind = ($urandom_range(1, 100) <= enq_pct) ? REQ_ENQ : REQ_DEQ;
			issue(kind, rand_value(), rand_prio());
		end
	endtask

	// back to back requests with the receiver never stalling
	task automatic test_streaming(input int count);
		stream_mode = 1'b1;
		test_random_traffic(count);
		stream_mode = 1'b0;
	endtask

	// main sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_dequeue();
		test_fill_overflow();
		test_drain_head();
		test_random_traffic(RANDOM_ITEMS);
		test_streaming(STREAM_ITEMS);

		req_valid <= 1'b0;
		while (owed_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d enqueues (%0d dropped while full), %0d dequeues (%0d on empty)",
			n_enq + n_dropped, n_dropped, n_deq + n_on_empty, n_on_empty);
		$display("peak fill %0d of %0d, %0d results checked, %0d mismatches",
			peak_fill, CAPACITY, n_checked, n_errors);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sorted_priority_queue_top.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
sim/sorted_priority_queue_top_tb.sv
